FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared constants, result kinds and the header status bundle of the BMP
// pixel stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int unsigned MAX_DIM = 4096;
    // Width of a stored image dimension (holds MAX_DIM itself).
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    // Width of the column and row counters (hold MAX_DIM - 1).
    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int COORD_W = 12;

    localparam logic [31:0] MAX_DIM_32    = 32'(MAX_DIM);
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_32        = 16'd32;
    localparam logic [31:0] HDR_SIZE      = 32'd54;
    localparam logic [5:0]  HDR_LAST_POS  = 6'd53;

    typedef enum logic [2:0] {
        KIND_PIXEL      = 3'd0,
        KIND_EMPTY      = 3'd1,
        KIND_BAD_SIG    = 3'd2,
        KIND_BAD_DEPTH  = 3'd3,
        KIND_COMPRESSED = 3'd4,
        KIND_BAD_SIZE   = 3'd5
    } kind_t;

    typedef struct packed {
        logic              done;    // header ends the file with one result
        kind_t             kind;    // kind of that result
        logic              skip;    // pixel data starts beyond the header
        logic [31:0]       offset;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  hmag;
        logic              neg;     // top-down row order
        logic              bpp32;
    } hdr_status_t;

endpackage

FILE: rtl/bmpd_hdr.sv
// ----------------------------------------------------------------------------
// bmpd_hdr
// Captures the header fields of a BMP file byte by byte and classifies the
// header: error kind, empty image, pixel-data offset and image geometry.
// ----------------------------------------------------------------------------
module bmpd_hdr (
    input  logic                  clk,
    input  logic                  start,
    input  logic                  wr,
    input  logic [5:0]            pos,
    input  logic [7:0]            data_byte,
    output bmpd_pkg::hdr_status_t status
);
    import bmpd_pkg::*;

    logic [15:0] sig_reg, sig_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [31:0] comp_reg, comp_next;
    logic [1:0]  lane_offset, lane_width, lane_height, lane_comp;
    logic [31:0] hmag32;
    logic        width_ok, hmag_ok;

    assign lane_offset = 2'(pos - 6'd10);
    assign lane_width  = 2'(pos - 6'd18);
    assign lane_height = 2'(pos - 6'd22);
    assign lane_comp   = 2'(pos - 6'd30);

    always_comb
    begin
        sig_next    = sig_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        comp_next   = comp_reg;
        if (start)
        begin
            // The first byte of a file is header byte zero.
            sig_next    = {8'd0, data_byte};
            offset_next = '0;
            width_next  = '0;
            height_next = '0;
            bpp_next    = '0;
            comp_next   = '0;
        end
        else if (wr)
        begin
            if (pos inside {[6'd0:6'd1]})
                sig_next[{pos[0], 3'b000} +: 8] = data_byte;
            else if (pos inside {[6'd10:6'd13]})
                offset_next[{lane_offset, 3'b000} +: 8] = data_byte;
            else if (pos inside {[6'd18:6'd21]})
                width_next[{lane_width, 3'b000} +: 8] = data_byte;
            else if (pos inside {[6'd22:6'd25]})
                height_next[{lane_height, 3'b000} +: 8] = data_byte;
            else if (pos inside {[6'd28:6'd29]})
                bpp_next[{pos[0], 3'b000} +: 8] = data_byte;
            else if (pos inside {[6'd30:6'd33]})
                comp_next[{lane_comp, 3'b000} +: 8] = data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg    <= sig_next;
        offset_reg <= offset_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        bpp_reg    <= bpp_next;
        comp_reg   <= comp_next;
    end

    assign hmag32   = height_reg[31] ? (32'd0 - height_reg) : height_reg;
    assign width_ok = !width_reg[31] && (width_reg != 32'd0) && (width_reg <= MAX_DIM_32);
    assign hmag_ok  = (hmag32 <= MAX_DIM_32);

    always_comb
    begin
        status.done   = 1'b1;
        status.kind   = KIND_PIXEL;
        status.skip   = (offset_reg > HDR_SIZE);
        status.offset = offset_reg;
        status.width  = DIM_W'(width_reg);
        status.hmag   = DIM_W'(hmag32);
        status.neg    = height_reg[31];
        status.bpp32  = (bpp_reg == BPP_32);
        // Checks in priority order; the first failure names the result.
        if (sig_reg != BMP_SIGNATURE)
            status.kind = KIND_BAD_SIG;
        else if ((bpp_reg != BPP_24) && (bpp_reg != BPP_32))
            status.kind = KIND_BAD_DEPTH;
        else if (comp_reg != 32'd0)
            status.kind = KIND_COMPRESSED;
        else if (!width_ok || !hmag_ok)
            status.kind = KIND_BAD_SIZE;
        else if (hmag32 == 32'd0)
            status.kind = KIND_EMPTY;
        else
            status.done = 1'b0;
    end

endmodule

FILE: rtl/bmp_pixel_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_core
// Parses a 24/32-bit uncompressed BMP byte stream; emits one RGB pixel with its
// column and top-first row per pixel group, or a status result if the header ends the file.
//
//   Channel   Dir  tdata (low bit up)                      tuser / tlast
//   s_*       in   data_byte[7:0]                          start_of_file / -
//   m_*       out  red, green, blue, column[11:0], row     kind[2:0] / last_pixel
//
// One byte is accepted per cycle when not stalled; its result, if any, appears
// in the output register on the next cycle.
// The rate is set by the single byte-wide parser step and the output register.
// Input stalls only while a result sits in the output register untaken.
// rst_n clears the parser asynchronously; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_pixel_stream_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red, green, blue, column, row
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last_pixel
);
    import bmpd_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_PIXELS = 5'b01000,
        PH_PAD    = 5'b10000
    } phase_t;

    localparam logic [1:0] BIP_BLUE  = 2'd0;
    localparam logic [1:0] BIP_GREEN = 2'd1;
    localparam logic [1:0] BIP_RED   = 2'd2;
    localparam logic [1:0] BIP_ALPHA = 2'd3;

    phase_t             phase_reg, phase_next;
    logic [31:0]        pos_reg, pos_next, pos_plus;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   hmag_reg, hmag_next;
    logic               neg_reg, neg_next;
    logic               bpp32_reg, bpp32_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [1:0]         bip_reg, bip_next;
    logic [1:0]         pad_reg, pad_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [7:0]         out_red_reg, out_green_reg, out_blue_reg;
    logic [COORD_W-1:0] out_col_reg, out_row_reg;
    logic               out_last_reg;

    logic               accept;
    logic               hdr_start, hdr_wr;
    hdr_status_t        hdr_status;
    logic               emit, emit_last;
    kind_t              emit_kind;
    logic [DIM_W-1:0]   col_plus, row_plus, orow;
    logic               col_last, row_last, pix_end;

    bmpd_hdr u_hdr (
        .clk       (clk),
        .start     (hdr_start),
        .wr        (hdr_wr),
        .pos       (pos_reg[5:0]),
        .data_byte (s_tdata),
        .status    (hdr_status)
    );

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign hdr_start = accept && s_tuser;

    assign col_plus = DIM_W'(col_reg) + DIM_W'(1);
    assign row_plus = DIM_W'(row_reg) + DIM_W'(1);
    assign col_last = (col_plus == width_reg);
    assign row_last = (row_plus == hmag_reg);
    assign orow     = neg_reg ? DIM_W'(row_reg) : (hmag_reg - row_plus);
    assign pix_end  = bpp32_reg ? (bip_reg == BIP_ALPHA) : (bip_reg == BIP_RED);
    assign pos_plus = pos_reg + 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        width_next = width_reg;
        hmag_next  = hmag_reg;
        neg_next   = neg_reg;
        bpp32_next = bpp32_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        bip_next   = bip_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        hdr_wr     = 1'b0;
        emit       = 1'b0;
        emit_kind  = KIND_PIXEL;
        emit_last  = 1'b0;
        if (accept)
        begin
            if (s_tuser)
            begin
                // Header byte zero is taken by the header unit directly.
                phase_next = PH_HEADER;
                pos_next   = 32'd1;
                col_next   = '0;
                row_next   = '0;
                bip_next   = BIP_BLUE;
                pad_next   = 2'd0;
                blue_next  = 8'd0;
                green_next = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_wr   = 1'b1;
                        pos_next = pos_plus;
                        if (pos_reg[5:0] == HDR_LAST_POS)
                        begin
                            if (hdr_status.done)
                            begin
                                emit       = 1'b1;
                                emit_kind  = hdr_status.kind;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                width_next = hdr_status.width;
                                hmag_next  = hdr_status.hmag;
                                neg_next   = hdr_status.neg;
                                bpp32_next = hdr_status.bpp32;
                                phase_next = hdr_status.skip ? PH_SKIP : PH_PIXELS;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        pos_next = pos_plus;
                        if (pos_plus >= hdr_status.offset)
                            phase_next = PH_PIXELS;
                    end
                    PH_PIXELS:
                    begin
                        if (bip_reg == BIP_BLUE)
                            blue_next = s_tdata;
                        else if (bip_reg == BIP_GREEN)
                            green_next = s_tdata;
                        else if (bip_reg == BIP_RED)
                        begin
                            emit      = 1'b1;
                            emit_last = col_last && row_last;
                        end
                        if (!pix_end)
                            bip_next = bip_reg + 2'd1;
                        else
                        begin
                            bip_next = BIP_BLUE;
                            if (!col_last)
                                col_next = col_reg + CNT_W'(1);
                            else
                            begin
                                col_next = '0;
                                if (row_last)
                                    phase_next = PH_IDLE;
                                else
                                begin
                                    row_next = row_reg + CNT_W'(1);
                                    // A 24-bit row of width w needs w mod 4 pad bytes.
                                    pad_next = bpp32_reg ? 2'd0 : width_reg[1:0];
                                    if (!bpp32_reg && (width_reg[1:0] != 2'd0))
                                        phase_next = PH_PAD;
                                end
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        pad_next = pad_reg - 2'd1;
                        if (pad_reg == 2'd1)
                            phase_next = PH_PIXELS;
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            width_reg     <= '0;
            hmag_reg      <= '0;
            neg_reg       <= 1'b0;
            bpp32_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            bip_reg       <= BIP_BLUE;
            pad_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            width_reg     <= width_next;
            hmag_reg      <= hmag_next;
            neg_reg       <= neg_next;
            bpp32_reg     <= bpp32_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bip_reg       <= bip_next;
            pad_reg       <= pad_next;
            out_valid_reg <= (accept && emit) || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        blue_reg  <= blue_next;
        green_reg <= green_next;
        if (accept && emit)
        begin
            out_kind_reg <= emit_kind;
            out_last_reg <= emit_last;
            if (emit_kind == KIND_PIXEL)
            begin
                out_red_reg   <= s_tdata;
                out_green_reg <= green_reg;
                out_blue_reg  <= blue_reg;
                out_col_reg   <= COORD_W'(col_reg);
                out_row_reg   <= COORD_W'(orow);
            end
            else
            begin
                out_red_reg   <= 8'd0;
                out_green_reg <= 8'd0;
                out_blue_reg  <= 8'd0;
                out_col_reg   <= '0;
                out_row_reg   <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_blue_reg, out_green_reg, out_red_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPL(a_status_fields_zero, m_tvalid && (m_tuser != KIND_PIXEL),
                 (m_tdata == 48'd0) && !m_tlast, "status result carries pixel fields")
    `ASSERT_IMPL(a_alpha_only_32, (phase_reg == PH_PIXELS) && (bip_reg == BIP_ALPHA),
                 bpp32_reg, "alpha byte position reached in a 24-bit image")
    `ASSERT_IMPL(a_pad_nonzero, phase_reg == PH_PAD, pad_reg != 2'd0,
                 "padding phase with no padding bytes left")
    `ASSERT_NEXT(a_last_ends_image, accept && emit && emit_last && pix_end,
                 phase_reg == PH_IDLE, "parser still active after the last pixel")
    `ASSERT_NEXT(a_result_loaded, accept && emit, m_tvalid,
                 "result produced but output register not loaded")

endmodule

FILE: bench/bmp_decode_sb_pkg.sv
// ----------------------------------------------------------------------------
// bmp_decode_sb_pkg
// Scoreboard for the BMP pixel stream decoder bench. It follows the parser
// byte by byte, queues the result that each accepted byte should cause and
// compares every result transaction against the oldest queued one.
// ----------------------------------------------------------------------------
package bmp_decode_sb_pkg;

    import bmpd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD
    } parse_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } decoded_t;

    class bmp_decode_scoreboard;

        parse_phase_t phase;
        logic [31:0]  byte_pos;
        logic [15:0]  signature;
        logic [31:0]  data_offset;
        logic [31:0]  raw_width;
        logic [31:0]  raw_height;
        logic [15:0]  bits_per_pixel;
        logic [31:0]  compression;
        logic [31:0]  col_cnt;
        logic [31:0]  row_cnt;
        logic [1:0]   byte_in_px;
        logic [1:0]   pad_left;
        logic [7:0]   held_blue;
        logic [7:0]   held_green;

        decoded_t     expected_results[$];
        int unsigned  failures;
        int unsigned  results_checked;

        function new();
            restart();
            failures = 0;
            results_checked = 0;
        endfunction

        function void restart();
            phase = PH_IDLE;
            byte_pos = '0;
            signature = '0;
            data_offset = '0;
            raw_width = '0;
            raw_height = '0;
            bits_per_pixel = '0;
            compression = '0;
            col_cnt = '0;
            row_cnt = '0;
            byte_in_px = '0;
            pad_left = '0;
            held_blue = '0;
            held_green = '0;
        endfunction

        function logic [31:0] height_mag();
            return raw_height[31] ? (32'd0 - raw_height) : raw_height;
        endfunction

        // Advances the parser by one accepted byte and queues its result.
        function void decode_byte(logic [7:0] b, logic sof);
            decoded_t    res;
            bit          emit;
            bit          group_end;
            int          pos;
            logic [31:0] hmag;
            logic [31:0] row_out;
            logic [31:0] row_len;

            res = '0;
            emit = 1'b0;
            if (sof)
            begin
                restart();
                phase = PH_HEADER;
            end

            case (phase)
                PH_HEADER:
                begin
                    pos = int'(byte_pos);
                    if (pos <= 1)
                        signature[8*pos +: 8] = b;
                    else if (pos >= 10 && pos <= 13)
                        data_offset[8*(pos-10) +: 8] = b;
                    else if (pos >= 18 && pos <= 21)
                        raw_width[8*(pos-18) +: 8] = b;
                    else if (pos >= 22 && pos <= 25)
                        raw_height[8*(pos-22) +: 8] = b;
                    else if (pos >= 28 && pos <= 29)
                        bits_per_pixel[8*(pos-28) +: 8] = b;
                    else if (pos >= 30 && pos <= 33)
                        compression[8*(pos-30) +: 8] = b;
                    byte_pos = byte_pos + 1;

                    if (pos == 53)
                    begin
                        phase = PH_IDLE;
                        hmag = height_mag();
                        emit = 1'b1;
                        // The checks run in a fixed order; the first failure wins.
                        if (signature != BMP_SIGNATURE)
                            res.kind = KIND_BAD_SIG;
                        else if (bits_per_pixel != BPP_24 && bits_per_pixel != BPP_32)
                            res.kind = KIND_BAD_DEPTH;
                        else if (compression != 32'd0)
                            res.kind = KIND_COMPRESSED;
                        else if (raw_width[31] || raw_width == 32'd0 ||
                                 raw_width > MAX_DIM_32 || hmag > MAX_DIM_32)
                            res.kind = KIND_BAD_SIZE;
                        else if (hmag == 32'd0)
                            res.kind = KIND_EMPTY;
                        else
                        begin
                            emit = 1'b0;
                            if (data_offset < HDR_SIZE)
                                data_offset = HDR_SIZE;
                            phase = (data_offset > HDR_SIZE) ? PH_SKIP : PH_PIXELS;
                        end
                    end
                end

                PH_SKIP:
                begin
                    byte_pos = byte_pos + 1;
                    if (byte_pos >= data_offset)
                        phase = PH_PIXELS;
                end

                PH_PIXELS:
                begin
                    hmag = height_mag();
                    case (byte_in_px)
                        2'd0: held_blue = b;
                        2'd1: held_green = b;
                        2'd2:
                        begin
                            emit = 1'b1;
                            res.kind = KIND_PIXEL;
                            res.red = b;
                            res.green = held_green;
                            res.blue = held_blue;
                            res.column = col_cnt[11:0];
                            // Bottom-up files store the last output row first.
                            row_out = raw_height[31] ? row_cnt : (hmag - 1 - row_cnt);
                            res.row = row_out[11:0];
                            res.last = (col_cnt + 1 == raw_width) && (row_cnt + 1 == hmag);
                        end
                        default: ;
                    endcase

                    group_end = (bits_per_pixel == BPP_32) ? (byte_in_px == 2'd3)
                                                           : (byte_in_px == 2'd2);
                    if (!group_end)
                        byte_in_px = byte_in_px + 1;
                    else
                    begin
                        byte_in_px = '0;
                        if (col_cnt + 1 < raw_width)
                            col_cnt = col_cnt + 1;
                        else
                        begin
                            col_cnt = '0;
                            if (row_cnt + 1 >= hmag)
                                phase = PH_IDLE;
                            else
                            begin
                                row_cnt = row_cnt + 1;
                                row_len = raw_width * 3;
                                pad_left = (bits_per_pixel == BPP_24) ? (2'd0 - row_len[1:0])
                                                                      : 2'd0;
                                if (pad_left != 2'd0)
                                    phase = PH_PAD;
                            end
                        end
                    end
                end

                PH_PAD:
                begin
                    pad_left = pad_left - 1;
                    if (pad_left == 2'd0)
                        phase = PH_PIXELS;
                end

                default: ;
            endcase

            if (emit)
                expected_results.push_back(res);
        endfunction

        function void check_result(logic [2:0] kind, logic [47:0] data, logic last);
            decoded_t got;
            decoded_t want;

            got.kind = kind_t'(kind);
            got.red = data[7:0];
            got.green = data[15:8];
            got.blue = data[23:16];
            got.column = data[35:24];
            got.row = data[47:36];
            got.last = last;
            results_checked++;

            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: kind %0d rgb %h/%h/%h col %0d row %0d last %b",
                             got.kind, got.red, got.green, got.blue, got.column, got.row,
                             got.last);
                return;
            end

            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.column !== want.column ||
                got.row !== want.row || got.last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch: expected kind %0d rgb %h/%h/%h col %0d row %0d last %b",
                             want.kind, want.red, want.green, want.blue, want.column,
                             want.row, want.last);
                    $display("          actual   kind %0d rgb %h/%h/%h col %0d row %0d last %b",
                             got.kind, got.red, got.green, got.blue, got.column, got.row,
                             got.last);
                end
            end
        endfunction

    endclass

endpackage

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for bmp_pixel_stream_decoder_core. Sends BMP files byte by byte:
// first hand-built files for each header error, the empty image, small and
// large offsets, both row orders, both depths, restarts and the largest
// dimensions, then mostly well-formed random small images mixed with corrupt
// headers and stray bytes. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bmpd_pkg::*;
    import bmp_decode_sb_pkg::*;

    localparam int unsigned CYCLE_LIMIT        = 1_000_000;
    localparam int unsigned HOLD_CYCLES        = 300;
    localparam int unsigned RANDOM_BYTES       = 560;
    localparam int unsigned DRAIN_CYCLES       = 4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic        s_tuser;    // start_of_file
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // red, green, blue, column, row
    logic [2:0]  m_tuser;    // kind
    logic        m_tlast;    // last_pixel

    bit          idle_on;
    bit          hold_request;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    logic [7:0]  file_bytes[$];

    bmp_decode_scoreboard sb = new();

    bmp_pixel_stream_decoder_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.decode_byte(s_tdata, s_tuser);
        end
    end

    // Result side: random backpressure, or a long hold-off when requested.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                m_tready <= !idle_on || ($urandom_range(99) >= 29);
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        while (idle_on && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sof;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0);
        bytes_sent += file_bytes.size();
    endtask

    task automatic add_random_bytes(input int unsigned count);
        repeat (count) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Starts a new file with a 54-byte header; unused header bytes are random.
    task automatic put_header(input logic [15:0] sig, input logic [31:0] offset,
                              input logic [31:0] width, input logic [31:0] height,
                              input logic [15:0] bpp, input logic [31:0] comp);
        file_bytes.delete();
        add_random_bytes(54);
        file_bytes[0] = sig[7:0];
        file_bytes[1] = sig[15:8];
        for (int i = 0; i < 4; i++)
        begin
            file_bytes[10+i] = offset[8*i +: 8];
            file_bytes[18+i] = width[8*i +: 8];
            file_bytes[22+i] = height[8*i +: 8];
            file_bytes[30+i] = comp[8*i +: 8];
        end
        file_bytes[28] = bpp[7:0];
        file_bytes[29] = bpp[15:8];
    endtask

    // Bytes after the header up to the end of the pixel data. Every row is
    // counted padded; the padding after the final row is ignored by the block.
    function automatic int unsigned image_body_len(logic [31:0] offset, logic [31:0] width,
                                                   logic [31:0] height, logic [15:0] bpp);
        logic [31:0] hmag;
        logic [31:0] row_len;
        hmag = height[31] ? (32'd0 - height) : height;
        row_len = width * ((bpp == BPP_32) ? 4 : 3);
        row_len = row_len + ((4 - row_len % 4) % 4);
        return ((offset > HDR_SIZE) ? offset - HDR_SIZE : 0) + hmag * row_len;
    endfunction

    task automatic send_valid_image(input logic [31:0] offset, input logic [31:0] width,
                                    input logic [31:0] height, input logic [15:0] bpp,
                                    input bit truncate);
        int unsigned body;
        body = image_body_len(offset, width, height, bpp);
        if (truncate && body > 1)
            body = $urandom_range(1, body - 1);
        put_header(BMP_SIGNATURE, offset, width, height, bpp, 32'd0);
        add_random_bytes(body);
        send_file();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
    endtask

    task automatic random_file();
        int unsigned pick;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] offset;
        logic [15:0] bpp;

        pick = $urandom_range(99);
        width = $urandom_range(1, 6);
        height = $urandom_range(0, 4);
        if ($urandom_range(1))
            height = 32'd0 - height;
        bpp = $urandom_range(1) ? BPP_32 : BPP_24;
        case ($urandom_range(3))
            0: offset = $urandom_range(53);
            1: offset = HDR_SIZE;
            default: offset = HDR_SIZE + $urandom_range(1, 10);
        endcase

        if (pick < 75)
            send_valid_image(offset, width, height, bpp, $urandom_range(99) < 15);
        else if (pick >= 95)
            // Stray bytes outside a file.
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)), 1'b0);
        else
        begin
            if (pick < 80)
                put_header(16'($urandom), offset, width, height, bpp, 32'd0);
            else if (pick < 85)
                put_header(BMP_SIGNATURE, offset, width, height, 16'($urandom), 32'd0);
            else if (pick < 90)
                put_header(BMP_SIGNATURE, offset, width, height, bpp, $urandom);
            else
                put_header(BMP_SIGNATURE, offset, $urandom, $urandom, bpp, 32'd0);
            add_random_bytes($urandom_range(0, 6));
            send_file();
        end
    endtask

    initial
    begin
        int unsigned start_bytes;
        int unsigned file_no;

        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        @(posedge rst_n);

        // Bytes while idle after reset are ignored.
        repeat (4) send_byte(8'($urandom_range(255)), 1'b0);

        // Header errors, each on its own file.
        put_header(16'h4D43, 32'd54, 32'd2, 32'd2, BPP_24, 32'd0);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, 32'd2, 32'd2, 16'd16, 32'd0);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, 32'd2, 32'd2, BPP_24, 32'd1);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, 32'd0, 32'd2, BPP_24, 32'd0);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, 32'hFFFF_FFFF, 32'd2, BPP_32, 32'd0);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, MAX_DIM_32 + 1, 32'd2, BPP_24, 32'd0);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, 32'd2, 32'h8000_0000, BPP_24, 32'd0);
        send_file();
        put_header(BMP_SIGNATURE, 32'd54, 32'd2, 32'd0 - (MAX_DIM_32 + 1), BPP_24, 32'd0);
        send_file();
        // Empty image.
        put_header(BMP_SIGNATURE, 32'd54, 32'd3, 32'd0, BPP_24, 32'd0);
        send_file();

        // Offset below the header, then one that needs skipping, both row orders.
        send_valid_image(32'd0, 32'd3, 32'd2, BPP_24, 1'b0);
        send_valid_image(32'd60, 32'd2, 32'd0 - 32'd3, BPP_32, 1'b0);
        send_valid_image(32'd55, 32'd1, 32'd3, BPP_24, 1'b0);
        repeat (3) send_byte(8'($urandom_range(255)), 1'b0);

        // Restart in the middle of the pixels and in the middle of a header.
        send_valid_image(32'd54, 32'd5, 32'd3, BPP_24, 1'b1);
        put_header(BMP_SIGNATURE, 32'd54, 32'd2, 32'd2, BPP_24, 32'd0);
        file_bytes = file_bytes[0:19];
        send_file();
        // An offset that is never reached.
        put_header(BMP_SIGNATURE, 32'hFFFF_FFFF, 32'd2, 32'd2, BPP_24, 32'd0);
        add_random_bytes(8);
        send_file();
        drain();

        // Widest row, cut after a few pixels, under a long result hold-off:
        // the block fills and stalls.
        hold_request = 1'b1;
        put_header(BMP_SIGNATURE, 32'd54, MAX_DIM_32, 32'd0 - 32'd1, BPP_24, 32'd0);
        add_random_bytes(48);
        send_file();
        // Tallest image, cut after a few rows to reach the highest output row numbers.
        put_header(BMP_SIGNATURE, 32'd54, 32'd1, MAX_DIM_32, BPP_24, 32'd0);
        add_random_bytes(12);
        send_file();

        start_bytes = bytes_sent;
        file_no = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            idle_on = !(file_no >= 1 && file_no < 4);
            if (file_no == 5)
                hold_request = 1'b1;
            if (file_no == 3)
                drain();
            random_file();
            file_no++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
